[design/i2smsd_pkg.sv]
// i2smsd_pkg: shared types, constants and helpers for the slot detect/extract block.
// No dependencies.
`default_nettype none
package i2smsd_pkg;

    localparam int FRAMES_PER_BLOCK = 256;
    localparam int FIB_W            = 12;
    localparam int ENERGY_W         = 32;
    localparam int WORD_W           = 16;
    localparam int CNT_W            = 8;
    localparam int SEL_W            = 2;
    localparam int PADDR_W          = 4;

    localparam logic [FIB_W-1:0] LAST_FRAME = FIB_W'(FRAMES_PER_BLOCK - 1);

    localparam logic [SEL_W-1:0] SEL_AUTO   = 2'd0;
    localparam logic [SEL_W-1:0] SEL_FIRST  = 2'd1;
    localparam logic [SEL_W-1:0] SEL_SECOND = 2'd2;

    localparam logic [1:0] REG_SLOT_SELECT    = 2'd0;
    localparam logic [1:0] REG_DISCARD_BLOCKS = 2'd1;
    localparam logic [1:0] REG_DETECT_BLOCKS  = 2'd2;

    typedef struct packed {
        logic signed [WORD_W-1:0] pcm_sample;
        logic                     slot_used;
        logic                     block_last;
    } t_result;

    // |word| of a signed 16-bit value; the most negative word gives 32768
    function automatic logic [WORD_W:0] magnitude16(input logic [WORD_W-1:0] w);
        logic [WORD_W:0] ext;
        ext = {1'b0, w};
        if (w[WORD_W-1]) begin
            return (17'h10000 - ext);
        end
        return ext;
    endfunction

endpackage
`default_nettype wire

[design/i2smsd_lane.sv]
// i2smsd_lane: one slot lane, magnitude and wrapping 32-bit energy accumulator.
// Depends on i2smsd_pkg.
`default_nettype none
module i2smsd_lane
    import i2smsd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [WORD_W-1:0]   i_word,
    input  wire logic                i_acc_en,
    input  wire logic                i_clear,
    output logic      [ENERGY_W-1:0] o_energy,
    output logic      [ENERGY_W-1:0] o_energy_next
);

    logic [ENERGY_W-1:0] r_energy;

    assign o_energy_next = r_energy + ENERGY_W'(magnitude16(i_word));
    assign o_energy      = r_energy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= '0;
        end else if (i_clear) begin
            r_energy <= '0;
        end else if (i_acc_en) begin
            r_energy <= o_energy_next;
        end
    end

endmodule
`default_nettype wire

[design/i2smsd_merge.sv]
// i2smsd_merge: combines the lanes - picks the louder slot and selects the output word.
// Depends on i2smsd_pkg.
`default_nettype none
module i2smsd_merge
    import i2smsd_pkg::*;
(
    input  wire logic [ENERGY_W-1:0] i_energy0,
    input  wire logic [ENERGY_W-1:0] i_energy1,
    input  wire logic [SEL_W-1:0]    i_slot_select,
    input  wire logic                i_slot_offset,
    input  wire logic [WORD_W-1:0]   i_slot0_word,
    input  wire logic [WORD_W-1:0]   i_slot1_word,
    input  wire logic                i_block_last,
    output logic                     o_pick,
    output t_result                  o_result
);

    logic sel;

    // tie goes to slot 0
    assign o_pick = (i_energy1 > i_energy0);

    always_comb begin
        case (i_slot_select)
            SEL_AUTO:   sel = i_slot_offset;
            SEL_SECOND: sel = 1'b1;
            default:    sel = 1'b0;
        endcase
        o_result.pcm_sample = sel ? i_slot1_word : i_slot0_word;
        o_result.slot_used  = sel;
        o_result.block_last = i_block_last;
    end

endmodule
`default_nettype wire

[design/i2smsd_outbuf.sv]
// i2smsd_outbuf: output register plus skid stage for result words.
// Depends on i2smsd_pkg.
`default_nettype none
module i2smsd_outbuf
    import i2smsd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_data
);

    logic    r_main_v;
    logic    r_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    take;

    assign take    = r_main_v && !i_stall;
    assign o_full  = r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_skid_v <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_v || take) begin
                r_main_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_main_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_v || take) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule
`default_nettype wire

[design/i2s_mic_slot_detect_extract_top.sv]
// i2s_mic_slot_detect_extract_top: top level, block counters, registers, lanes and merge.
// Depends on i2smsd_pkg, i2smsd_lane, i2smsd_merge, i2smsd_outbuf.
//
// Takes one stereo frame word per cycle and updates its block, discard and detection
// state in that same cycle: two slot lanes accumulate |sample| side by side and a
// merge stage compares the two energies on the last detect block. Results reach the
// output through a register with a skid stage, so input is stalled only while that
// skid stage is occupied; with no output stall the rate is one word per clock and
// output valid follows in the cycle after input acceptance.
`default_nettype none
module i2s_mic_slot_detect_extract_top
    import i2smsd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_restart,
    input  wire logic [WORD_W-1:0]   i_slot0_word,
    input  wire logic [WORD_W-1:0]   i_slot1_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic signed [WORD_W-1:0] o_pcm_sample,
    output logic                     o_slot_used,
    output logic                     o_block_last,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    logic [SEL_W-1:0] r_slot_select;
    logic [CNT_W-1:0] r_discard_blocks;
    logic [CNT_W-1:0] r_detect_blocks;
    logic [CNT_W-1:0] r_discard_count;
    logic [CNT_W-1:0] r_detect_count;
    logic             r_slot_locked;
    logic             r_slot_offset;
    logic [FIB_W-1:0] r_frame_in_block;

    logic                accept;
    logic                restart_acc;
    logic                frame;
    logic                last;
    logic                in_discard;
    logic                in_detect;
    logic                emit;
    logic                lock_now;
    logic [CNT_W-1:0]    n_detect_count;
    logic [ENERGY_W-1:0] energy0;
    logic [ENERGY_W-1:0] energy1;
    logic [ENERGY_W-1:0] energy0_next;
    logic [ENERGY_W-1:0] energy1_next;
    logic                pick;
    logic                cfg_wr;
    t_result             result;
    t_result             out_data;

    assign accept      = i_in_valid && !o_in_stall;
    assign restart_acc = accept && i_restart;
    assign frame       = accept && !i_restart;
    assign last        = (r_frame_in_block >= LAST_FRAME);
    assign in_discard  = (r_discard_count < r_discard_blocks);
    assign in_detect   = !in_discard && (r_slot_select == SEL_AUTO) && !r_slot_locked;
    assign emit        = frame && !in_discard && !in_detect;
    assign n_detect_count = r_detect_count + CNT_W'(1);
    assign lock_now    = frame && in_detect && last && (n_detect_count >= r_detect_blocks);

    i2smsd_lane u_lane0 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_word        (i_slot0_word),
        .i_acc_en      (frame && in_detect),
        .i_clear       (restart_acc),
        .o_energy      (energy0),
        .o_energy_next (energy0_next)
    );

    i2smsd_lane u_lane1 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_word        (i_slot1_word),
        .i_acc_en      (frame && in_detect),
        .i_clear       (restart_acc),
        .o_energy      (energy1),
        .o_energy_next (energy1_next)
    );

    i2smsd_merge u_merge (
        .i_energy0     (energy0_next),
        .i_energy1     (energy1_next),
        .i_slot_select (r_slot_select),
        .i_slot_offset (r_slot_offset),
        .i_slot0_word  (i_slot0_word),
        .i_slot1_word  (i_slot1_word),
        .i_block_last  (last),
        .o_pick        (pick),
        .o_result      (result)
    );

    i2smsd_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_data  (result),
        .o_full  (o_in_stall),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_data)
    );

    assign o_pcm_sample = out_data.pcm_sample;
    assign o_slot_used  = out_data.slot_used;
    assign o_block_last = out_data.block_last;

    // run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_discard_count  <= '0;
            r_detect_count   <= '0;
            r_slot_locked    <= 1'b0;
            r_slot_offset    <= 1'b0;
            r_frame_in_block <= '0;
        end else if (restart_acc) begin
            r_discard_count  <= '0;
            r_detect_count   <= '0;
            r_slot_locked    <= 1'b0;
            r_frame_in_block <= '0;
        end else if (frame) begin
            r_frame_in_block <= last ? '0 : r_frame_in_block + FIB_W'(1);
            if (in_discard) begin
                if (last) begin
                    r_discard_count <= r_discard_count + CNT_W'(1);
                end
            end else if (in_detect && last) begin
                r_detect_count <= n_detect_count;
                if (lock_now) begin
                    r_slot_offset <= pick;
                    r_slot_locked <= 1'b1;
                end
            end
        end
    end

    // register port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_select    <= SEL_AUTO;
            r_discard_blocks <= CNT_W'(4);
            r_detect_blocks  <= CNT_W'(4);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SLOT_SELECT:    r_slot_select    <= pwdata[SEL_W-1:0];
                REG_DISCARD_BLOCKS: r_discard_blocks <= pwdata[CNT_W-1:0];
                REG_DETECT_BLOCKS:  r_detect_blocks  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SLOT_SELECT:    prdata = {30'd0, r_slot_select};
            REG_DISCARD_BLOCKS: prdata = {24'd0, r_discard_blocks};
            REG_DETECT_BLOCKS:  prdata = {24'd0, r_detect_blocks};
            default:            prdata = '0;
        endcase
    end

    // a result is never produced while the skid stage is occupied
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !o_in_stall)
        else $error("result pushed into full output buffer");

    // restart clears both energies and the lock
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart_acc |=> (energy0 == '0) && (energy1 == '0) && !r_slot_locked)
        else $error("restart did not clear detection state");

    // a lock only happens on the last frame of a block
    a_lock_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_slot_locked) |-> $past(frame && last))
        else $error("slot locked away from a block boundary");

endmodule
`default_nettype wire
